/* hdl/psr_pkg.sv */
// ----------------------------------------------------------------------------
// psr_pkg: shared constants for the polyphase sinc resampler
// Register map, reset values, item kinds and fixed widths of the arithmetic.
// ----------------------------------------------------------------------------
package psr_pkg;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_CPS    = 2'd0;
	localparam logic [1:0] REG_TAPS   = 2'd1;
	localparam logic [1:0] REG_PHASES = 2'd2;

	// register widths and reset values
	localparam int CPS_W    = 20;
	localparam int TAPCNT_W = 11;
	localparam int PHCNT_W  = 6;
	localparam logic [CPS_W-1:0]    CPS_RESET    = 20'd22877;
	localparam logic [TAPCNT_W-1:0] TAPS_RESET   = 11'd1475;
	localparam logic [PHCNT_W-1:0]  PHASES_RESET = 6'd13;

	// input item kinds
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	// phase accumulator: one input tick is 1 << FRAC_W
	localparam int ACC_W   = 22;
	localparam int FRAC_W  = 10;
	localparam logic [ACC_W-1:0] PHASE_ONE = 22'd1024;

	// coefficient scaling: sums rounded by 2^14 and shifted by 15
	localparam int COEF_SHIFT = 15;
	localparam int ROUND_BIT  = 14;

	// sample clipping limits
	localparam logic signed [31:0] CLIP_MAX = 32'sd32767;
	localparam logic signed [31:0] CLIP_MIN = -32'sd32768;

	// saturated output limits
	localparam logic [31:0] OUT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] OUT_MIN = 32'h8000_0000;

endpackage

/* hdl/polyphase_sinc_resampler.sv */
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler
// Polyphase sinc resampler with linear interpolation between adjacent phase
// tables, built around one shared 16x16 multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser req_type, tdata sample/coef
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata sample_out
//  apb       in   psel, penable, pready          paddr, pwdata, prdata
//
//  coefficient writes and non-emitting sample ticks complete without leaving idle
//  an emitting tick runs the single multiply-accumulate unit, which walks both
//  windows one tap per cycle
//  s_axis_tready is low while a convolution runs; the result sits in an output
//  register, and the block waits in its last step only if that is still full
//  the sample ring needs no clearing pass: a fill count masks unwritten entries
// ----------------------------------------------------------------------------
module polyphase_sinc_resampler
	import psr_pkg::*;
#(
	parameter int RING_SIZE  = 2048,
	parameter int MAX_TAPS   = 2047,
	parameter int MAX_PHASES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic        s_axis_tuser,   // [0] req_type
	input  logic [63:0] s_axis_tdata,   // [31:0] sample_in, [36:32] coef_phase,
	                                    // [47:37] coef_tap, [63:48] coef_value
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sample_out
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// derived sizes
	localparam int RI_W    = $clog2(RING_SIZE);
	localparam int FILL_W  = $clog2(RING_SIZE + 1);
	localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int N_W     = $clog2(MAX_TAPS + 1);
	localparam int PH_W    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int PC_W    = $clog2(MAX_PHASES + 1);
	localparam int P_W     = FRAC_W + PC_W;
	localparam int CA_W    = PH_W + TAP_W;
	localparam int COEF_DEPTH = MAX_PHASES * (1 << TAP_W);
	localparam int SUM_W   = 32 + $clog2(MAX_TAPS + 1);
	localparam int V_W     = SUM_W - COEF_SHIFT;
	localparam int MI_W    = V_W + FRAC_W + 2;
	localparam int RES_W   = V_W + 2;
	localparam int SAT_W   = (RES_W > 33) ? RES_W : 33;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAC   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	// input field unpacking
	logic                req_type;
	logic signed [31:0]  sample_in;
	logic [4:0]          coef_phase;
	logic [10:0]         coef_tap;
	logic signed [15:0]  coef_value;

	assign req_type   = s_axis_tuser;
	assign sample_in  = s_axis_tdata[31:0];
	assign coef_phase = s_axis_tdata[36:32];
	assign coef_tap   = s_axis_tdata[47:37];
	assign coef_value = s_axis_tdata[63:48];

	// state and configuration
	logic [2:0]          state_q;
	logic                pass_q;
	logic [N_W-1:0]      cnt_q;
	logic                vld_s1, vld_s2;
	logic [RI_W-1:0]     wp_q;
	logic [FILL_W-1:0]   fill_q;
	logic [ACC_W-1:0]    acc_q;
	logic [CPS_W-1:0]    cps_q;
	logic [TAPCNT_W-1:0] taps_q;
	logic [PHCNT_W-1:0]  phases_q;
	logic                out_valid_q;

	// datapath registers
	logic [RI_W-1:0]     idx_q;
	logic [PH_W-1:0]     tab_q, tab2_q;
	logic [RI_W-1:0]     top2_q;
	logic [N_W-1:0]      n_q;
	logic [FRAC_W-1:0]   f_q;
	logic signed [15:0]  ring_rd_s1, coef_rd_s1;
	logic                rvalid_s1;
	logic signed [31:0]  prod_s2;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [V_W-1:0]   v1_q, v2_q;
	logic signed [MI_W-1:0]  mi_q;
	logic [31:0]         out_data_q;

	// memories
	logic signed [15:0]  ring_mem [RING_SIZE];
	logic signed [15:0]  coef_mem [COEF_DEPTH];

	// handshakes
	logic in_fire, tick_fire, coef_fire, emit_fire, cfg_wr, out_free, out_load, issue;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign tick_fire = in_fire && (req_type == REQ_SAMPLE);
	assign coef_fire = in_fire && (req_type == REQ_COEF);
	assign emit_fire = tick_fire && (acc_q < PHASE_ONE);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign out_load  = (state_q == S_FIN) && out_free;
	assign issue     = (state_q == S_MAC) && (cnt_q != '0);
	assign pready    = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_CPS:    prdata = 32'(cps_q);
			REG_TAPS:   prdata = 32'(taps_q);
			REG_PHASES: prdata = 32'(phases_q);
			default:    prdata = '0;
		endcase
	end

	// input sample clipping
	logic signed [15:0] clip_c;
	always_comb begin
		priority if (sample_in > CLIP_MAX) clip_c = CLIP_MAX[15:0];
		else if (sample_in < CLIP_MIN)     clip_c = CLIP_MIN[15:0];
		else                               clip_c = sample_in[15:0];
	end

	// clamped phase count and tap count
	logic [31:0]    pc_full, n_full;
	logic [PC_W-1:0] pc_c;
	logic [N_W-1:0]  n_c;
	always_comb begin
		priority if (phases_q == '0)            pc_full = 32'd1;
		else if (32'(phases_q) > MAX_PHASES)    pc_full = 32'(MAX_PHASES);
		else                                    pc_full = 32'(phases_q);
		if (32'(taps_q) > MAX_TAPS) n_full = 32'(MAX_TAPS);
		else                        n_full = 32'(taps_q);
	end
	assign pc_c = PC_W'(pc_full);
	assign n_c  = N_W'(n_full);

	// phase split into table index and fraction
	logic [P_W-1:0]    p_c;
	logic [PC_W-1:0]   t_c;
	logic [PC_W:0]     t_inc_c;
	logic              wrap_c;
	logic [PH_W-1:0]   t2_c;
	logic [RI_W-1:0]   top1_c, top2_c;
	assign p_c     = acc_q[FRAC_W-1:0] * pc_c;
	assign t_c     = p_c[P_W-1:FRAC_W];
	assign t_inc_c = {1'b0, t_c} + 1'b1;
	assign wrap_c  = (t_inc_c == {1'b0, pc_c});
	assign t2_c    = wrap_c ? '0 : PH_W'(t_inc_c);
	// newest tap sits two behind the advanced pointer, one when the window shifts
	assign top1_c  = (wp_q == '0) ? RI_W'(RING_SIZE - 1) : wp_q - 1'b1;
	assign top2_c  = wrap_c ? wp_q : top1_c;

	// accumulator update, ratio clamped to at least one tick
	logic [CPS_W-1:0] cps_c;
	assign cps_c = (cps_q < CPS_W'(PHASE_ONE)) ? CPS_W'(PHASE_ONE) : cps_q;

	// rounding and interpolation arithmetic
	logic signed [SUM_W-1:0] rsum_c;
	logic signed [V_W-1:0]   v_c;
	logic signed [V_W:0]     diff_c;
	logic signed [RES_W-1:0] res_c;
	logic signed [SAT_W-1:0] res_ext_c;
	logic [31:0]             sat_c;
	assign rsum_c    = sum_q + SUM_W'(1 << ROUND_BIT);
	assign v_c       = rsum_c[SUM_W-1:COEF_SHIFT];
	assign diff_c    = (V_W+1)'(v2_q) - (V_W+1)'(v1_q);
	assign res_c     = RES_W'(v1_q) + mi_q[MI_W-1:FRAC_W];
	assign res_ext_c = SAT_W'(res_c);
	always_comb begin
		if ((&res_ext_c[SAT_W-1:31]) || !(|res_ext_c[SAT_W-1:31])) sat_c = res_ext_c[31:0];
		else if (res_ext_c[SAT_W-1])                               sat_c = OUT_MIN;
		else                                                       sat_c = OUT_MAX;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q    <= CPS_RESET;
			taps_q   <= TAPS_RESET;
			phases_q <= PHASES_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CPS:    cps_q    <= pwdata[CPS_W-1:0];
				REG_TAPS:   taps_q   <= pwdata[TAPCNT_W-1:0];
				REG_PHASES: phases_q <= pwdata[PHCNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// sequencer, ring pointer, fill count and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (out_load)           out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (tick_fire) begin
						wp_q <= (wp_q == RI_W'(RING_SIZE - 1)) ? '0 : wp_q + 1'b1;
						if (fill_q != FILL_W'(RING_SIZE)) fill_q <= fill_q + 1'b1;
						if (emit_fire) begin
							acc_q   <= acc_q + ACC_W'(cps_c) - PHASE_ONE;
							cnt_q   <= n_c;
							pass_q  <= 1'b0;
							state_q <= S_MAC;
						end else begin
							acc_q <= acc_q - PHASE_ONE;
						end
					end
				end
				S_MAC: begin
					if (issue) cnt_q   <= cnt_q - 1'b1;
					else       state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!vld_s1 && !vld_s2) state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						cnt_q   <= n_q;
						state_q <= S_MAC;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// window walk, operands and results
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			n_q    <= n_c;
			idx_q  <= top1_c;
			top2_q <= top2_c;
			tab_q  <= PH_W'(t_c);
			tab2_q <= t2_c;
			f_q    <= p_c[FRAC_W-1:0];
		end else if (issue) begin
			idx_q <= (idx_q == '0) ? RI_W'(RING_SIZE - 1) : idx_q - 1'b1;
		end else if (state_q == S_ROUND && !pass_q) begin
			idx_q <= top2_q;
			tab_q <= tab2_q;
		end
		if (state_q == S_ROUND) begin
			if (!pass_q) v1_q <= v_c;
			else         v2_q <= v_c;
		end
		if (state_q == S_MUL) mi_q <= MI_W'($signed({1'b0, f_q}) * diff_c);
		if (out_load) out_data_q <= sat_c;
	end

	// shared multiply-accumulate unit: read, multiply, accumulate
	logic [N_W-1:0] tap_m1_c;
	assign tap_m1_c = cnt_q - 1'b1;

	always_ff @(posedge clk) begin
		rvalid_s1 <= FILL_W'(idx_q) < fill_q;
		prod_s2   <= (rvalid_s1 ? ring_rd_s1 : 16'sd0) * coef_rd_s1;
		if (emit_fire || (state_q == S_ROUND && !pass_q)) sum_q <= '0;
		else if (vld_s2)                                  sum_q <= sum_q + SUM_W'(prod_s2);
	end

	// sample ring
	always_ff @(posedge clk) begin
		if (tick_fire) ring_mem[wp_q] <= clip_c;
		ring_rd_s1 <= ring_mem[idx_q];
	end

	// coefficient tables, one row of taps per phase
	always_ff @(posedge clk) begin
		if (coef_fire && 32'(coef_phase) < MAX_PHASES && 32'(coef_tap) < MAX_TAPS)
			coef_mem[{PH_W'(coef_phase), TAP_W'(coef_tap)}] <= coef_value;
		coef_rd_s1 <= coef_mem[{tab_q, tap_m1_c[TAP_W-1:0]}];
	end

	// checks
	a_emit_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> state_q == S_MAC)
		else $error("emitting tick did not start the convolution");

	a_issue_only_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q) == S_MAC)
		else $error("tap read issued outside the convolution");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_SIZE))
		else $error("ring fill count beyond ring size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) || !out_valid_q)
		else $error("pending result overwritten");

	a_round_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (!vld_s1 && !vld_s2))
		else $error("sum rounded before the pipeline drained");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for polyphase_sinc_resampler
// Feeds sample ticks and coefficient loads through the input stream, steps a
// bit-exact resampler model on every accepted item and compares each output
// item against it. Runs over a series of register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
	import psr_pkg::*;

	localparam int RING_DEPTH  = 2048;
	localparam int TAP_LIMIT   = 2047;
	localparam int PHASE_LIMIT = 32;
	localparam int SETTINGS_N  = 7;
	localparam int IDLE_LIMIT  = 20000;
	localparam int CONFIG_GAP  = 20;
	localparam int FINAL_WAIT  = 4200;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] cps;
		logic [31:0] taps;
		logic [31:0] tables;
		int          ticks;
	} setting_t;

	// resampler model and queue of outputs still due
	class resample_scoreboard;
		logic signed [15:0]  ring [RING_DEPTH];
		logic signed [15:0]  coef [PHASE_LIMIT][TAP_LIMIT];
		bit                  loaded [PHASE_LIMIT][TAP_LIMIT];
		logic [10:0]         wr_ptr;
		logic [ACC_W-1:0]    acc;
		logic [CPS_W-1:0]    cps;
		logic [TAPCNT_W-1:0] taps;
		logic [PHCNT_W-1:0]  tables;
		logic [31:0]         due_outputs [$];
		int unsigned         errors, items_seen, coef_loads, outputs_checked;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			wr_ptr = '0;
			acc = '0;
			cps = CPS_RESET;
			taps = TAPS_RESET;
			tables = PHASES_RESET;
			errors = 0;
			items_seen = 0;
			coef_loads = 0;
			outputs_checked = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_CPS:    cps = value[CPS_W-1:0];
				REG_TAPS:   taps = value[TAPCNT_W-1:0];
				REG_PHASES: tables = value[PHCNT_W-1:0];
				default:    ;
			endcase
		endfunction

		function int unsigned live_taps();
			return (taps > TAP_LIMIT) ? TAP_LIMIT : taps;
		endfunction

		function int unsigned live_tables();
			if (tables == 0)
				return 1;
			return (tables > PHASE_LIMIT) ? PHASE_LIMIT : tables;
		endfunction

		// rounded dot product of one window with one phase table
		function longint window_sum(logic [10:0] first, int unsigned tbl, int unsigned n);
			longint      sum;
			logic [10:0] idx;
			sum = 0;
			for (int unsigned k = 0; k < n; k++) begin
				idx = first + 11'(k);
				sum += longint'(ring[idx]) * longint'(coef[tbl][k]);
			end
			return (sum + (longint'(1) << ROUND_BIT)) >>> COEF_SHIFT;
		endfunction

		function void absorb_item(logic req, logic [63:0] data);
			logic signed [31:0] raw;
			logic signed [15:0] clipped;
			logic [10:0]        first;
			int unsigned        n, pc, p, t, f;
			longint             v1, v2, res;
			items_seen++;
			// coefficient load, tap index past the table is dropped
			if (req == REQ_COEF) begin
				coef_loads++;
				if (data[47:37] < TAP_LIMIT) begin
					coef[data[36:32]][data[47:37]] = data[63:48];
					loaded[data[36:32]][data[47:37]] = 1'b1;
				end
				return;
			end
			// clip the sample into the ring
			raw = data[31:0];
			clipped = (raw > CLIP_MAX) ? CLIP_MAX[15:0] :
				(raw < CLIP_MIN) ? CLIP_MIN[15:0] : raw[15:0];
			ring[wr_ptr] = clipped;
			wr_ptr = wr_ptr + 11'd1;
			// ticks that emit nothing only drain the accumulator
			if (acc >= PHASE_ONE) begin
				acc = acc - PHASE_ONE;
				return;
			end
			n = live_taps();
			pc = live_tables();
			p = acc * pc;
			t = p >> FRAC_W;
			f = p & 32'h3ff;
			first = wr_ptr - 11'(n) - 11'd1;
			v1 = window_sum(first, t, n);
			// wrap to table 0 with the window one sample later
			t++;
			if (t == pc) begin
				t = 0;
				first = first + 11'd1;
			end
			v2 = window_sum(first, t, n);
			res = v1 + ((longint'(f) * (v2 - v1)) >>> FRAC_W);
			if (res > 64'sh7fff_ffff)
				res = 64'sh7fff_ffff;
			if (res < -64'sh8000_0000)
				res = -64'sh8000_0000;
			due_outputs.push_back(res[31:0]);
			acc = acc + ((cps < PHASE_ONE) ? PHASE_ONE : ACC_W'(cps)) - PHASE_ONE;
		endfunction

		function void note_error(string msg);
			if (errors < 10)
				$display("tb: mismatch: %s", msg);
			errors++;
		endfunction

		function void check_output(logic [31:0] got);
			logic [31:0] want;
			outputs_checked++;
			if (due_outputs.size() == 0) begin
				note_error($sformatf("output item %0d not expected, sample_out %0d",
					outputs_checked, $signed(got)));
				return;
			end
			want = due_outputs.pop_front();
			if (got !== want)
				note_error($sformatf("output item %0d sample_out expected %0d got %0d",
					outputs_checked, $signed(want), $signed(got)));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic        s_axis_tuser;   // [0] req_type
	logic [63:0] s_axis_tdata;   // [31:0] sample_in, [36:32] coef_phase,
	                             // [47:37] coef_tap, [63:48] coef_value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;   // [31:0] sample_out
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned        send_gap_pct = 0;
	int unsigned        recv_stall_pct = 0;
	int unsigned        quiet_cycles = 0;
	resample_scoreboard sb;
	setting_t           plan [SETTINGS_N];

	polyphase_sinc_resampler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// model stepping and output comparison
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.absorb_item(s_axis_tuser, s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_output(m_axis_tdata);
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: no item moved for %0d cycles", IDLE_LIMIT);
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] coef_item(logic [4:0] tbl, logic [10:0] tap,
			logic [15:0] value, logic [31:0] filler);
		return {value, tap, tbl, filler};
	endfunction

	// tvalid stays high from one item to the next unless a gap is drawn
	task automatic send_item(input logic req, input logic [63:0] data);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	// wait for every due output, then let the block settle
	task automatic drain(input int settle);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_outputs.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		logic [31:0] sample;
		logic [4:0]  tbl;
		logic [10:0] tap;
		int unsigned used_n, used_pc;
		int          ticks_sent;

		sb = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser  <= REQ_SAMPLE;
		s_axis_tdata  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;

		// ratio, taps, tables, sample ticks
		plan[0] = '{32'd0, 32'd1, 32'd1, 150};
		plan[1] = '{32'd1023, 32'd0, 32'd0, 60};
		plan[2] = '{32'd22877, 32'd15, 32'd13, 260};
		plan[3] = '{32'd1500, 32'd2, 32'd32, 220};
		plan[4] = '{32'd5000, 32'd6, 32'd63, 220};
		plan[5] = '{32'd1024, 32'd511, 32'd1, 10};
		plan[6] = '{32'd1048575, 32'd3, 32'd7, 40};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SETTINGS_N; i++) begin
			case (i % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 75; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 75; end
				default: begin send_gap_pct = 22; recv_stall_pct = 22; end
			endcase
			write_reg(REG_CPS, plan[i].cps);
			write_reg(REG_TAPS, plan[i].taps);
			write_reg(REG_PHASES, plan[i].tables);
			if (i == 0)
				write_reg(REG_UNUSED, 32'hffff_ffff);

			// load every coefficient this setting can read
			used_n = sb.live_taps();
			used_pc = sb.live_tables();
			for (int t = 0; t < used_pc; t++)
				for (int k = 0; k < used_n; k++)
					if (!sb.loaded[t][k])
						send_item(REQ_COEF,
							coef_item(5'(t), 11'(k), 16'($urandom()), $urandom()));

			// clipping edges, coefficient extremes, dropped loads
			if (i == 0) begin
				send_item(REQ_COEF, coef_item(5'd0, 11'd0, 16'h7fff, 32'h0));
				send_item(REQ_SAMPLE, {32'h0, 32'h7fff_ffff});
				send_item(REQ_SAMPLE, {32'hffff_ffff, 32'h8000_0000});
				send_item(REQ_COEF, coef_item(5'd0, 11'd0, 16'h8000, 32'hffff_ffff));
				send_item(REQ_SAMPLE, {32'h0, 32'h0000_7fff});
				send_item(REQ_SAMPLE, {32'h0, 32'hffff_8000});
				send_item(REQ_SAMPLE, {32'h0, 32'h0000_8000});
				send_item(REQ_SAMPLE, {32'h0, 32'hffff_7fff});
				send_item(REQ_COEF, '1);
				send_item(REQ_SAMPLE, '0);
				send_item(REQ_SAMPLE, {32'h0, 32'hffff_ffff});
				send_item(REQ_COEF, coef_item(5'd31, 11'd2046, 16'h0001, 32'h0));
				send_item(REQ_COEF, coef_item(5'd0, 11'd2047, 16'h1234, 32'h0));
				send_item(REQ_SAMPLE, {32'h0, 32'h0000_0001});
				send_item(REQ_COEF, coef_item(5'd0, 11'd0, 16'h4000, 32'h0));
				send_item(REQ_SAMPLE, {32'h0, 32'h0001_2345});
				send_item(REQ_COEF, '0);
				send_item(REQ_SAMPLE, {32'h0, 32'hfffe_dcba});
			end

			// random ticks with coefficient reloads mixed in
			ticks_sent = 0;
			while (ticks_sent < plan[i].ticks) begin
				if ($urandom_range(99) < 12) begin
					if (used_n != 0 && $urandom_range(1) == 1) begin
						tbl = 5'($urandom_range(used_pc - 1));
						tap = 11'($urandom_range(used_n - 1));
					end else begin
						tbl = 5'($urandom_range(31));
						tap = 11'($urandom_range(2047));
					end
					send_item(REQ_COEF, coef_item(tbl, tap, 16'($urandom()), $urandom()));
				end else begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4: sample = 32'(int'($urandom_range(65535)) - 32768);
						5, 6, 7:       sample = $urandom();
						8:             sample = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
						default:       sample = 32'(int'($urandom_range(4)) - 2) +
							($urandom_range(1) ? 32'h0000_7fff : 32'hffff_8000);
					endcase
					send_item(REQ_SAMPLE, {$urandom(), sample});
					ticks_sent++;
				end
			end
			drain((i == SETTINGS_N - 1) ? FINAL_WAIT : CONFIG_GAP);
		end

		if (sb.due_outputs.size() != 0)
			sb.note_error($sformatf("%0d expected output items never arrived",
				sb.due_outputs.size()));
		$display("tb: %0d register settings, %0d input items (%0d coefficient loads)",
			SETTINGS_N, sb.items_seen, sb.coef_loads);
		$display("tb: %0d output items compared, %0d mismatches",
			sb.outputs_checked, sb.errors);
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
